>>> hdl/stcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcs_pkg
// Shared types and constants for the stitch-counted trim and blow sequencer.
// ----------------------------------------------------------------------------
package stcs_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 32;
    localparam int TMR_W      = 16;

    localparam logic [CNT_W-1:0] NOISE_STITCHES = 32'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUT_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_PULSE_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_STITCHES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_STITCHES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_ENTRY_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_EXIT_MS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_RUN_MS     = 3'd7;

    // mode codes
    localparam logic [2:0] CUT_BOTH  = 3'd1;
    localparam logic [2:0] CUT_ENTRY = 3'd2;
    localparam logic [2:0] CUT_EXIT  = 3'd3;
    localparam logic [2:0] AIR_BOTH  = 3'd1;
    localparam logic [2:0] AIR_ENTRY = 3'd2;
    localparam logic [2:0] AIR_EXIT  = 3'd3;
    localparam logic [2:0] AIR_RUN   = 3'd4;

    // reset values of the configuration registers
    localparam logic [2:0]       RST_CUT_MODE       = CUT_BOTH;
    localparam logic [2:0]       RST_AIR_MODE       = AIR_BOTH;
    localparam logic [TMR_W-1:0] RST_CUT_PULSE_MS   = 16'd200;
    localparam logic [TMR_W-1:0] RST_ENTRY_STITCHES = 16'd10;
    localparam logic [TMR_W-1:0] RST_EXIT_STITCHES  = 16'd20;
    localparam logic [TMR_W-1:0] RST_AIR_ENTRY_MS   = 16'd1000;
    localparam logic [TMR_W-1:0] RST_AIR_EXIT_MS    = 16'd3000;
    localparam logic [TMR_W-1:0] RST_AIR_RUN_MS     = 16'd5000;

    // action flag bits
    localparam int FL_CUT_IN   = 0;
    localparam int FL_CUT_OUT  = 1;
    localparam int FL_AIR_IN   = 2;
    localparam int FL_AIR_OUT  = 3;
    localparam int FL_AIR_FULL = 4;
    localparam int FL_CYC_END  = 5;
    localparam int FL_W        = 6;

    typedef enum logic [1:0] {
        PH_WAIT_FABRIC = 2'd0,
        PH_ENTRY       = 2'd1,
        PH_WAIT_END    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]       cut_mode;
        logic [2:0]       air_mode;
        logic [TMR_W-1:0] cut_pulse_ms;
        logic [TMR_W-1:0] entry_stitches;
        logic [TMR_W-1:0] exit_stitches;
        logic [TMR_W-1:0] air_entry_ms;
        logic [TMR_W-1:0] air_exit_ms;
        logic [TMR_W-1:0] air_run_ms;
    } cfg_t;

    typedef struct packed {
        logic             cut_relay;
        logic             air_relay;
        logic             fabric_present;
        logic [1:0]       phase;
        logic [CNT_W-1:0] stitches_since_change;
        logic [CNT_W-1:0] last_cycle_stitches;
    } res_t;

endpackage

>>> hdl/stitch_counted_trim_and_blow_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stitch_counted_trim_and_blow_sequencer_top
// Tick-driven trim and air-blow sequencer: request register, sequencer core,
// result register and configuration registers.
// ----------------------------------------------------------------------------
// Path: request register, then tick update into the result register.
// Throughput: one request per cycle while the result is not stalled; the tick
// update is one pass of logic between the request and result registers.
// Reset: asynchronous, active low; clears all sequencer state and loads the
// configuration registers with their default values.
module stitch_counted_trim_and_blow_sequencer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           count_sensor,
    input  logic                           fabric_sensor,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           cut_relay,
    output logic                           air_relay,
    output logic                           fabric_present,
    output logic [1:0]                     phase,
    output logic [stcs_pkg::CNT_W-1:0]     stitches_since_change,
    output logic [stcs_pkg::CNT_W-1:0]     last_cycle_stitches,
    input  logic                           cfg_we,
    input  logic [stcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stcs_pkg::*;

    cfg_t cfg_reg;
    logic req_vld_reg, req_vld_next;
    logic cnt_reg, fab_reg;
    logic rsp_vld_reg, rsp_vld_next;
    res_t rsp_reg;
    res_t core_res;
    logic advance, step, accept;

    assign advance   = !rsp_vld_reg || !rsp_stall;
    assign step      = req_vld_reg && advance;
    assign req_stall = req_vld_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        req_vld_next = req_vld_reg;
        if (accept)
        begin
            req_vld_next = 1'b1;
        end
        else if (step)
        begin
            req_vld_next = 1'b0;
        end

        rsp_vld_next = rsp_vld_reg;
        if (step)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg <= count_sensor;
            fab_reg <= fabric_sensor;
        end
        if (step)
        begin
            rsp_reg <= core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_mode       <= RST_CUT_MODE;
            cfg_reg.air_mode       <= RST_AIR_MODE;
            cfg_reg.cut_pulse_ms   <= RST_CUT_PULSE_MS;
            cfg_reg.entry_stitches <= RST_ENTRY_STITCHES;
            cfg_reg.exit_stitches  <= RST_EXIT_STITCHES;
            cfg_reg.air_entry_ms   <= RST_AIR_ENTRY_MS;
            cfg_reg.air_exit_ms    <= RST_AIR_EXIT_MS;
            cfg_reg.air_run_ms     <= RST_AIR_RUN_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUT_MODE:       cfg_reg.cut_mode       <= cfg_data[2:0];
                REG_AIR_MODE:       cfg_reg.air_mode       <= cfg_data[2:0];
                REG_CUT_PULSE_MS:   cfg_reg.cut_pulse_ms   <= cfg_data;
                REG_ENTRY_STITCHES: cfg_reg.entry_stitches <= cfg_data;
                REG_EXIT_STITCHES:  cfg_reg.exit_stitches  <= cfg_data;
                REG_AIR_ENTRY_MS:   cfg_reg.air_entry_ms   <= cfg_data;
                REG_AIR_EXIT_MS:    cfg_reg.air_exit_ms    <= cfg_data;
                REG_AIR_RUN_MS:     cfg_reg.air_run_ms     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    stcs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .count_sensor  (cnt_reg),
        .fabric_sensor (fab_reg),
        .cfg           (cfg_reg),
        .res           (core_res)
    );

    assign rsp_valid             = rsp_vld_reg;
    assign cut_relay             = rsp_reg.cut_relay;
    assign air_relay             = rsp_reg.air_relay;
    assign fabric_present        = rsp_reg.fabric_present;
    assign phase                 = rsp_reg.phase;
    assign stitches_since_change = rsp_reg.stitches_since_change;
    assign last_cycle_stitches   = rsp_reg.last_cycle_stitches;

endmodule

>>> hdl/stcs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcs_core
// Sequencer state and the per-tick update: stitch counting, fabric tracking,
// phase logic and the cut / air pulse timers.
// ----------------------------------------------------------------------------
module stcs_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          count_sensor,
    input  logic          fabric_sensor,
    input  stcs_pkg::cfg_t cfg,
    output stcs_pkg::res_t res
);
    import stcs_pkg::*;

    logic             count_prev_reg, count_prev_next;
    logic             fabric_prev_reg, fabric_prev_next;
    logic             fabric_flag_reg, fabric_flag_next;
    logic [CNT_W-1:0] stitch_total_reg, stitch_total_next;
    logic [CNT_W-1:0] change_mark_reg, change_mark_next;
    logic [CNT_W-1:0] cycle_start_reg, cycle_start_next;
    logic [CNT_W-1:0] cycle_end_reg, cycle_end_next;
    logic [CNT_W-1:0] prev_len_reg, prev_len_next;
    phase_t           phase_reg, phase_next;
    logic [FL_W-1:0]  flags_reg, flags_next;
    logic             cut_on_reg, cut_on_next;
    logic             air_on_reg, air_on_next;
    logic [TMR_W-1:0] cut_el_reg, cut_el_next;
    logic [TMR_W-1:0] air_el_reg, air_el_next;
    logic [TMR_W-1:0] air_dur_reg, air_dur_next;

    logic             stitch;
    logic [CNT_W-1:0] since;
    logic             cut_entry_en, cut_exit_en, air_entry_en, air_exit_en;

    assign cut_entry_en = (cfg.cut_mode == CUT_BOTH) || (cfg.cut_mode == CUT_ENTRY);
    assign cut_exit_en  = (cfg.cut_mode == CUT_BOTH) || (cfg.cut_mode == CUT_EXIT);
    assign air_entry_en = (cfg.air_mode == AIR_BOTH) || (cfg.air_mode == AIR_ENTRY);
    assign air_exit_en  = (cfg.air_mode == AIR_BOTH) || (cfg.air_mode == AIR_EXIT);

    always_comb
    begin
        count_prev_next   = count_prev_reg;
        fabric_prev_next  = fabric_prev_reg;
        fabric_flag_next  = fabric_flag_reg;
        stitch_total_next = stitch_total_reg;
        change_mark_next  = change_mark_reg;
        cycle_start_next  = cycle_start_reg;
        cycle_end_next    = cycle_end_reg;
        prev_len_next     = prev_len_reg;
        phase_next        = phase_reg;
        flags_next        = flags_reg;
        cut_on_next       = cut_on_reg;
        air_on_next       = air_on_reg;
        cut_el_next       = cut_el_reg;
        air_el_next       = air_el_reg;
        air_dur_next      = air_dur_reg;

        // elapsed timers saturate
        if (cut_el_reg != {TMR_W{1'b1}})
        begin
            cut_el_next = cut_el_reg + 1'b1;
        end
        if (air_el_reg != {TMR_W{1'b1}})
        begin
            air_el_next = air_el_reg + 1'b1;
        end

        stitch = (count_sensor != count_prev_reg);
        if (stitch)
        begin
            stitch_total_next = stitch_total_reg + 1'b1;
            count_prev_next   = count_sensor;
        end

        if (fabric_sensor != fabric_prev_reg)
        begin
            fabric_flag_next = fabric_sensor;
            change_mark_next = stitch_total_next;
            fabric_prev_next = fabric_sensor;
        end

        since = stitch_total_next - change_mark_next;

        unique case (phase_reg)
            PH_WAIT_FABRIC:
            begin
                if (since > NOISE_STITCHES && fabric_flag_next)
                begin
                    phase_next       = PH_ENTRY;
                    cycle_start_next = stitch_total_next;
                end
            end
            PH_ENTRY:
            begin
                if (cut_entry_en)
                begin
                    if (!flags_next[FL_CUT_IN] && since > {16'd0, cfg.entry_stitches})
                    begin
                        // armed exit cut or no fabric: mark done, no fire
                        if (!flags_next[FL_CYC_END] && fabric_flag_next)
                        begin
                            cut_el_next = '0;
                            cut_on_next = 1'b1;
                        end
                        flags_next[FL_CUT_IN] = 1'b1;
                    end
                end
                else
                begin
                    flags_next[FL_CUT_IN] = 1'b1;
                end
                if (air_entry_en)
                begin
                    if (!flags_next[FL_AIR_IN])
                    begin
                        air_dur_next = cfg.air_entry_ms;
                        air_el_next  = '0;
                        air_on_next  = 1'b1;
                        flags_next[FL_AIR_IN] = 1'b1;
                    end
                end
                else
                begin
                    flags_next[FL_AIR_IN] = 1'b1;
                end
                if (flags_next[FL_CUT_IN] && flags_next[FL_AIR_IN])
                begin
                    phase_next = PH_WAIT_END;
                end
            end
            PH_WAIT_END:
            begin
                if (since > NOISE_STITCHES && !fabric_flag_next)
                begin
                    if (air_exit_en && !flags_next[FL_AIR_OUT])
                    begin
                        air_dur_next = cfg.air_exit_ms;
                        air_el_next  = '0;
                        air_on_next  = 1'b1;
                    end
                    flags_next[FL_CUT_IN]  = 1'b0;
                    flags_next[FL_CUT_OUT] = 1'b0;
                    flags_next[FL_AIR_IN]  = 1'b0;
                    flags_next[FL_AIR_OUT] = 1'b0;
                    flags_next[FL_CYC_END] = 1'b1;
                    cycle_end_next = stitch_total_next;
                    prev_len_next  = stitch_total_next - cycle_start_next;
                    phase_next     = PH_WAIT_FABRIC;
                end
            end
            default:
            begin
            end
        endcase

        // run blast: each stitch starts it or restarts its timer
        if (stitch && cfg.air_mode == AIR_RUN)
        begin
            if (!flags_next[FL_AIR_FULL])
            begin
                flags_next[FL_AIR_FULL] = 1'b1;
                air_dur_next = cfg.air_run_ms;
                air_el_next  = '0;
                air_on_next  = 1'b1;
            end
            else
            begin
                air_el_next = '0;
            end
        end

        if (flags_next[FL_CYC_END])
        begin
            if (stitch_total_next - cycle_end_next > {16'd0, cfg.exit_stitches})
            begin
                if (cut_exit_en && !flags_next[FL_CUT_OUT])
                begin
                    cut_el_next = '0;
                    cut_on_next = 1'b1;
                end
                flags_next[FL_CUT_OUT] = 1'b1;
                flags_next[FL_CYC_END] = 1'b0;
            end
        end

        if (air_el_next >= air_dur_next)
        begin
            air_on_next = 1'b0;
            flags_next[FL_AIR_FULL] = 1'b0;
        end
        if (cut_el_next >= cfg.cut_pulse_ms)
        begin
            cut_on_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_prev_reg   <= 1'b0;
            fabric_prev_reg  <= 1'b0;
            fabric_flag_reg  <= 1'b0;
            stitch_total_reg <= '0;
            change_mark_reg  <= '0;
            cycle_start_reg  <= '0;
            cycle_end_reg    <= '0;
            prev_len_reg     <= '0;
            phase_reg        <= PH_WAIT_FABRIC;
            flags_reg        <= '0;
            cut_on_reg       <= 1'b0;
            air_on_reg       <= 1'b0;
            cut_el_reg       <= '0;
            air_el_reg       <= '0;
            air_dur_reg      <= '0;
        end
        else if (step)
        begin
            count_prev_reg   <= count_prev_next;
            fabric_prev_reg  <= fabric_prev_next;
            fabric_flag_reg  <= fabric_flag_next;
            stitch_total_reg <= stitch_total_next;
            change_mark_reg  <= change_mark_next;
            cycle_start_reg  <= cycle_start_next;
            cycle_end_reg    <= cycle_end_next;
            prev_len_reg     <= prev_len_next;
            phase_reg        <= phase_next;
            flags_reg        <= flags_next;
            cut_on_reg       <= cut_on_next;
            air_on_reg       <= air_on_next;
            cut_el_reg       <= cut_el_next;
            air_el_reg       <= air_el_next;
            air_dur_reg      <= air_dur_next;
        end
    end

    assign res.cut_relay             = cut_on_next;
    assign res.air_relay             = air_on_next;
    assign res.fabric_present        = fabric_flag_next;
    assign res.phase                 = phase_next;
    assign res.stitches_since_change = since;
    assign res.last_cycle_stitches   = prev_len_next;

endmodule

>>> tb/sv/stitch_counted_trim_and_blow_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stitch_counted_trim_and_blow_sequencer_top_tb
// Drives sensor ticks into the trim and blow sequencer and checks each tick
// result against a cycle-accurate predictor kept in a scoreboard class. The
// run uses several register settings, including the extremes, and changes
// the request and result flow patterns between settings.
// ----------------------------------------------------------------------------
module stitch_counted_trim_and_blow_sequencer_top_tb;

    import stcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;

    // mode values that select no action
    localparam logic [2:0] MODE_OFF_LO = 3'd0;
    localparam logic [2:0] MODE_OFF_HI = 3'd7;

    class trim_blow_scoreboard;
        cfg_t             regs;
        logic             cnt_prev, fab_prev, fabric_flag;
        logic [CNT_W-1:0] stitch_total, change_mark, cycle_start_mark;
        logic [CNT_W-1:0] cycle_end_mark, prev_cycle_len, shown_stitch;
        phase_t           step_phase;
        logic [FL_W-1:0]  flags;
        logic             cut_on, air_on;
        logic [TMR_W-1:0] cut_elapsed, air_elapsed, air_duration;
        res_t             expected_ticks[$];
        int               errors;

        function new();
            regs = '{RST_CUT_MODE, RST_AIR_MODE, RST_CUT_PULSE_MS, RST_ENTRY_STITCHES,
                     RST_EXIT_STITCHES, RST_AIR_ENTRY_MS, RST_AIR_EXIT_MS,
                     RST_AIR_RUN_MS};
            cnt_prev = 1'b0;
            fab_prev = 1'b0;
            fabric_flag = 1'b0;
            stitch_total = '0;
            change_mark = '0;
            cycle_start_mark = '0;
            cycle_end_mark = '0;
            prev_cycle_len = '0;
            shown_stitch = '0;
            step_phase = PH_WAIT_FABRIC;
            flags = '0;
            cut_on = 1'b0;
            air_on = 1'b0;
            cut_elapsed = '0;
            air_elapsed = '0;
            air_duration = '0;
            errors = 0;
        endfunction

        function void fire_cut();
            cut_elapsed = '0;
            cut_on = 1'b1;
        endfunction

        function void fire_air(logic [TMR_W-1:0] dur);
            air_duration = dur;
            air_elapsed = '0;
            air_on = 1'b1;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // advance one tick and queue the result it must produce
        function void note_request(logic cnt, logic fab);
            logic [CNT_W-1:0] since;
            res_t             tick;
            if (cut_elapsed != '1)
                cut_elapsed++;
            if (air_elapsed != '1)
                air_elapsed++;

            if (cnt != cnt_prev)
            begin
                stitch_total++;
                cnt_prev = cnt;
            end
            if (fab != fab_prev)
            begin
                fabric_flag = fab;
                change_mark = stitch_total;
                fab_prev = fab;
            end

            since = stitch_total - change_mark;
            case (step_phase)
                PH_WAIT_FABRIC:
                begin
                    if (since > NOISE_STITCHES && fabric_flag)
                    begin
                        step_phase = PH_ENTRY;
                        cycle_start_mark = stitch_total;
                    end
                end
                PH_ENTRY:
                begin
                    if (regs.cut_mode == CUT_BOTH || regs.cut_mode == CUT_ENTRY)
                    begin
                        if (!flags[FL_CUT_IN] && since > CNT_W'(regs.entry_stitches))
                        begin
                            // armed exit cut or missing fabric: done, no pulse
                            if (!flags[FL_CYC_END] && fabric_flag)
                                fire_cut();
                            flags[FL_CUT_IN] = 1'b1;
                        end
                    end
                    else
                        flags[FL_CUT_IN] = 1'b1;
                    if (regs.air_mode == AIR_BOTH || regs.air_mode == AIR_ENTRY)
                    begin
                        if (!flags[FL_AIR_IN])
                        begin
                            fire_air(regs.air_entry_ms);
                            flags[FL_AIR_IN] = 1'b1;
                        end
                    end
                    else
                        flags[FL_AIR_IN] = 1'b1;
                    if (flags[FL_CUT_IN] && flags[FL_AIR_IN])
                        step_phase = PH_WAIT_END;
                end
                PH_WAIT_END:
                begin
                    if (since > NOISE_STITCHES && !fabric_flag)
                    begin
                        if ((regs.air_mode == AIR_BOTH || regs.air_mode == AIR_EXIT)
                            && !flags[FL_AIR_OUT])
                            fire_air(regs.air_exit_ms);
                        flags[FL_CUT_IN]  = 1'b0;
                        flags[FL_CUT_OUT] = 1'b0;
                        flags[FL_AIR_IN]  = 1'b0;
                        flags[FL_AIR_OUT] = 1'b0;
                        flags[FL_CYC_END] = 1'b1;
                        cycle_end_mark = stitch_total;
                        prev_cycle_len = cycle_end_mark - cycle_start_mark;
                        step_phase = PH_WAIT_FABRIC;
                    end
                end
                default: ;
            endcase

            // run blast: a stitch fires it while it is off and only restarts the timer while it runs
            if (shown_stitch != stitch_total)
            begin
                if (regs.air_mode == AIR_RUN)
                begin
                    if (!flags[FL_AIR_FULL])
                    begin
                        flags[FL_AIR_FULL] = 1'b1;
                        fire_air(regs.air_run_ms);
                    end
                    else
                        air_elapsed = '0;
                end
                shown_stitch = stitch_total;
            end

            if (flags[FL_CYC_END])
            begin
                if (stitch_total - cycle_end_mark > CNT_W'(regs.exit_stitches))
                begin
                    if ((regs.cut_mode == CUT_BOTH || regs.cut_mode == CUT_EXIT)
                        && !flags[FL_CUT_OUT])
                        fire_cut();
                    flags[FL_CUT_OUT] = 1'b1;
                    flags[FL_CYC_END] = 1'b0;
                end
            end

            if (air_elapsed >= air_duration)
            begin
                air_on = 1'b0;
                flags[FL_AIR_FULL] = 1'b0;
            end
            if (cut_elapsed >= regs.cut_pulse_ms)
                cut_on = 1'b0;

            tick.cut_relay = cut_on;
            tick.air_relay = air_on;
            tick.fabric_present = fabric_flag;
            tick.phase = step_phase;
            tick.stitches_since_change = stitch_total - change_mark;
            tick.last_cycle_stitches = prev_cycle_len;
            expected_ticks.push_back(tick);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_ticks.size() == 0)
            begin
                $error("tick result with no request outstanding");
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("cut_relay", CNT_W'(want.cut_relay), CNT_W'(got.cut_relay));
            compare_field("air_relay", CNT_W'(want.air_relay), CNT_W'(got.air_relay));
            compare_field("fabric_present", CNT_W'(want.fabric_present),
                          CNT_W'(got.fabric_present));
            compare_field("phase", CNT_W'(want.phase), CNT_W'(got.phase));
            compare_field("stitches_since_change", want.stitches_since_change,
                          got.stitches_since_change);
            compare_field("last_cycle_stitches", want.last_cycle_stitches,
                          got.last_cycle_stitches);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  count_sensor = 1'b0;
    logic                  fabric_sensor = 1'b0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  cut_relay, air_relay, fabric_present;
    logic [1:0]            phase;
    logic [CNT_W-1:0]      stitches_since_change, last_cycle_stitches;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    trim_blow_scoreboard board;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic lvl_count = 1'b0;
    logic lvl_fabric = 1'b0;

    stitch_counted_trim_and_blow_sequencer_top dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .req_valid             (req_valid),
        .req_stall             (req_stall),
        .count_sensor          (count_sensor),
        .fabric_sensor         (fabric_sensor),
        .rsp_valid             (rsp_valid),
        .rsp_stall             (rsp_stall),
        .cut_relay             (cut_relay),
        .air_relay             (air_relay),
        .fabric_present        (fabric_present),
        .phase                 (phase),
        .stitches_since_change (stitches_since_change),
        .last_cycle_stitches   (last_cycle_stitches),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    always #2 clk = ~clk;

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result('{cut_relay, air_relay, fabric_present, phase,
                                 stitches_since_change, last_cycle_stitches});
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic cnt, input logic fab);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        count_sensor <= cnt;
        fabric_sensor <= fab;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(cnt, fab);
    endtask

    // fabric held in runs, stitches at random, with the odd one-tick glitch
    task automatic sew(input int n_items);
        int run_left;
        run_left = $urandom_range(1, 20);
        repeat (n_items)
        begin
            if (run_left == 0)
            begin
                lvl_fabric = ~lvl_fabric;
                run_left = $urandom_range(4, 40);
            end
            run_left--;
            if ($urandom_range(99) < 60)
                lvl_count = ~lvl_count;
            if ($urandom_range(99) < 5)
                send_request(lvl_count, ~lvl_fabric);
            else
                send_request(lvl_count, lvl_fabric);
        end
    endtask

    // wait for every outstanding result before touching registers
    task automatic settle();
        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        logic [CFG_DATA_W-1:0] cut_word, air_word;
        // junk above the mode bits must be ignored
        cut_word = CFG_DATA_W'($urandom);
        cut_word[2:0] = s.cut_mode;
        air_word = CFG_DATA_W'($urandom);
        air_word[2:0] = s.air_mode;
        write_reg(REG_CUT_MODE, cut_word);
        write_reg(REG_AIR_MODE, air_word);
        write_reg(REG_CUT_PULSE_MS, s.cut_pulse_ms);
        write_reg(REG_ENTRY_STITCHES, s.entry_stitches);
        write_reg(REG_EXIT_STITCHES, s.exit_stitches);
        write_reg(REG_AIR_ENTRY_MS, s.air_entry_ms);
        write_reg(REG_AIR_EXIT_MS, s.air_exit_ms);
        write_reg(REG_AIR_RUN_MS, s.air_run_ms);
        cfg_we <= 1'b0;
        board.regs = s;
    endtask

    initial
    begin
        cfg_t s;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default settings: stitches with no fabric, then one full cycle
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b0);
        for (int i = 0; i < 14; i++)
            send_request(~i[0], 1'b1);
        for (int i = 0; i < 5; i++)
            send_request(~i[0], 1'b0);
        lvl_count = 1'b1;
        lvl_fabric = 1'b0;

        settle();
        load_settings('{CUT_BOTH, AIR_BOTH, 16'd5, 16'd2, 16'd3, 16'd12, 16'd20, 16'd8});
        sew(130);

        settle();
        load_settings('{CUT_EXIT, AIR_RUN, 16'd3, 16'd0, 16'd1, 16'd6, 16'd9, 16'd10});
        send_idle_pct = 76;
        sew(120);

        settle();
        load_settings('{CUT_ENTRY, AIR_ENTRY, 16'd1, 16'd6, 16'd25, 16'd0, 16'd4, 16'd7});
        send_idle_pct = 0;
        stall_pct = 76;
        sew(120);

        settle();
        load_settings('{MODE_OFF_LO, AIR_EXIT, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
                        16'hFFFF});
        send_idle_pct = 20;
        stall_pct = 20;
        sew(110);

        // long result hold-off while requests keep coming
        settle();
        load_settings('{MODE_OFF_HI, MODE_OFF_HI, 16'hFFFF, 16'd1, 16'hFFFF, 16'd3, 16'd5,
                        16'd0});
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        sew(100);

        for (int k = 0; k < 3; k++)
        begin
            settle();
            s.cut_mode = 3'($urandom_range(7));
            s.air_mode = 3'($urandom_range(7));
            s.cut_pulse_ms = TMR_W'($urandom_range(40));
            s.entry_stitches = TMR_W'($urandom_range(8));
            s.exit_stitches = TMR_W'($urandom_range(8));
            s.air_entry_ms = TMR_W'($urandom_range(40));
            s.air_exit_ms = TMR_W'($urandom_range(40));
            s.air_run_ms = TMR_W'($urandom_range(40));
            load_settings(s);
            send_idle_pct = (k == 1) ? 76 : 20;
            stall_pct = (k == 2) ? 76 : 20;
            sew(50);
        end

        req_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
